[hdl/scld_pkg.sv]
package scld_pkg;

    // Characters kept per line; later characters of the line are dropped.
    localparam int LINE_LIMIT = 15;
    localparam int CNT_W      = $clog2(LINE_LIMIT + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;

    // Mode in which servo and drive lines are honored.
    localparam logic [1:0] MODE_REMOTE = 2'd3;

    typedef enum logic [1:0] {
        KIND_MODE  = 2'd0,
        KIND_SERVO = 2'd1,
        KIND_DRIVE = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_STOP
    } t_num_phase;

    typedef struct packed {
        logic clr;
        logic feed;
    } t_num_ctl;

    typedef struct packed {
        logic       mode_hit;
        logic [1:0] mode_val;
        logic       servo_hit;
        logic [1:0] servo_num;
        logic       drive_hit;
    } t_line_stat;

    // Characters of the mode prefix, position 0 to 4.
    function automatic logic [7:0] modo_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = CH_M;
            3'd1:    c = CH_O;
            3'd2:    c = CH_D;
            3'd3:    c = CH_O;
            default: c = CH_COLON;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

[hdl/scld_num.sv]
module scld_num (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  scld_pkg::t_num_ctl      i_ctl,
    input  logic [7:0]              i_byte,
    output logic signed [15:0]      o_value
);

    scld_pkg::t_num_phase r_phase, n_phase;
    logic                 r_neg, n_neg;
    logic [15:0]          r_acc, n_acc;
    logic [15:0]          digit;

    assign digit = {12'd0, i_byte[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= scld_pkg::NUM_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_ctl.clr) begin
            n_phase = scld_pkg::NUM_SKIP;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else if (i_ctl.feed) begin
            case (r_phase)
                scld_pkg::NUM_SKIP: begin
                    if (scld_pkg::is_blank(i_byte)) begin
                        n_phase = scld_pkg::NUM_SKIP;
                    end else if (i_byte == scld_pkg::CH_PLUS || i_byte == scld_pkg::CH_MINUS) begin
                        n_neg   = (i_byte == scld_pkg::CH_MINUS);
                        n_phase = scld_pkg::NUM_DIGITS;
                    end else if (scld_pkg::is_digit(i_byte)) begin
                        n_acc   = digit;
                        n_phase = scld_pkg::NUM_DIGITS;
                    end else begin
                        n_phase = scld_pkg::NUM_STOP;
                    end
                end
                scld_pkg::NUM_DIGITS: begin
                    if (scld_pkg::is_digit(i_byte)) begin
                        // acc * 10 + digit, modulo 2^16
                        n_acc = (r_acc << 3) + (r_acc << 1) + digit;
                    end else begin
                        n_phase = scld_pkg::NUM_STOP;
                    end
                end
                default: begin
                    n_phase = scld_pkg::NUM_STOP;
                end
            endcase
        end
    end

    assign o_value = r_neg ? $signed(16'd0 - r_acc) : $signed(r_acc);

endmodule

[hdl/scld_line.sv]
module scld_line (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [7:0]              i_byte,
    output scld_pkg::t_line_stat    o_stat,
    output scld_pkg::t_num_ctl      o_num1_ctl,
    output scld_pkg::t_num_ctl      o_num2_ctl
);

    logic [scld_pkg::CNT_W-1:0] r_count, n_count;
    logic       r_dead, n_dead;
    logic       r_mod_ok, n_mod_ok;
    logic       r_s_ok, n_s_ok;
    logic       r_c_ok, n_c_ok;
    logic       r_mode_hit, n_mode_hit;
    logic [1:0] r_mode_val, n_mode_val;
    logic       r_s_hit, n_s_hit;
    logic [1:0] r_servo_num, n_servo_num;
    logic       r_c_hit, n_c_hit;
    logic       r_comma, n_comma;
    logic       eol;

    assign eol = i_take && (i_byte == scld_pkg::CH_LF || i_byte == scld_pkg::CH_CR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dead      <= 1'b0;
            r_mod_ok    <= 1'b1;
            r_s_ok      <= 1'b0;
            r_c_ok      <= 1'b0;
            r_mode_hit  <= 1'b0;
            r_mode_val  <= '0;
            r_s_hit     <= 1'b0;
            r_servo_num <= '0;
            r_c_hit     <= 1'b0;
            r_comma     <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dead      <= n_dead;
            r_mod_ok    <= n_mod_ok;
            r_s_ok      <= n_s_ok;
            r_c_ok      <= n_c_ok;
            r_mode_hit  <= n_mode_hit;
            r_mode_val  <= n_mode_val;
            r_s_hit     <= n_s_hit;
            r_servo_num <= n_servo_num;
            r_c_hit     <= n_c_hit;
            r_comma     <= n_comma;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_dead      = r_dead;
        n_mod_ok    = r_mod_ok;
        n_s_ok      = r_s_ok;
        n_c_ok      = r_c_ok;
        n_mode_hit  = r_mode_hit;
        n_mode_val  = r_mode_val;
        n_s_hit     = r_s_hit;
        n_servo_num = r_servo_num;
        n_c_hit     = r_c_hit;
        n_comma     = r_comma;
        o_num1_ctl  = '{clr: eol, feed: 1'b0};
        o_num2_ctl  = '{clr: eol, feed: 1'b0};
        if (eol) begin
            // start a fresh line
            n_count     = '0;
            n_dead      = 1'b0;
            n_mod_ok    = 1'b1;
            n_s_ok      = 1'b0;
            n_c_ok      = 1'b0;
            n_mode_hit  = 1'b0;
            n_mode_val  = '0;
            n_s_hit     = 1'b0;
            n_servo_num = '0;
            n_c_hit     = 1'b0;
            n_comma     = 1'b0;
        end else if (i_take && !r_dead &&
                     r_count < scld_pkg::CNT_W'(scld_pkg::LINE_LIMIT)) begin
            n_count = r_count + 1'b1;
            if (i_byte == scld_pkg::CH_NUL) begin
                // a zero byte ends the decoded text
                n_dead = 1'b1;
            end else begin
                if (r_count < scld_pkg::CNT_W'(5)) begin
                    if (i_byte != scld_pkg::modo_char(r_count[2:0])) begin
                        n_mod_ok = 1'b0;
                    end
                end else if (r_count == scld_pkg::CNT_W'(5)) begin
                    if (r_mod_ok && i_byte inside {[scld_pkg::CH_1:scld_pkg::CH_3]}) begin
                        n_mode_hit = 1'b1;
                        n_mode_val = i_byte[1:0];
                    end
                    n_mod_ok = 1'b0;
                end

                if (r_count == scld_pkg::CNT_W'(0)) begin
                    n_s_ok = (i_byte == scld_pkg::CH_S);
                    n_c_ok = (i_byte == scld_pkg::CH_C);
                end else if (r_count == scld_pkg::CNT_W'(1)) begin
                    if (r_s_ok && i_byte inside {[scld_pkg::CH_1:scld_pkg::CH_4]}) begin
                        n_servo_num = 2'(i_byte - scld_pkg::CH_1);
                    end else begin
                        n_s_ok = 1'b0;
                    end
                    if (r_c_ok && i_byte == scld_pkg::CH_COLON) begin
                        n_c_hit = 1'b1;
                    end
                    n_c_ok = 1'b0;
                end else if (r_count == scld_pkg::CNT_W'(2)) begin
                    if (r_s_ok && i_byte == scld_pkg::CH_COLON) begin
                        n_s_hit = 1'b1;
                    end
                    n_s_ok = 1'b0;
                end

                // route body characters to the number parsers
                if (r_s_hit) begin
                    o_num1_ctl.feed = 1'b1;
                end else if (r_c_hit) begin
                    if (!r_comma) begin
                        if (i_byte == scld_pkg::CH_COMMA) begin
                            n_comma = 1'b1;
                        end else begin
                            o_num1_ctl.feed = 1'b1;
                        end
                    end else begin
                        o_num2_ctl.feed = 1'b1;
                    end
                end
            end
        end
    end

    assign o_stat = '{
        mode_hit:  r_mode_hit,
        mode_val:  r_mode_val,
        servo_hit: r_s_hit,
        servo_num: r_servo_num,
        drive_hit: r_c_hit && r_comma
    };

endmodule

[hdl/serial_command_line_decoder.sv]
// Serial command line decoder. Feed received characters one per request on
// i_rx_byte; a line ends at CR or LF and only its first 15 characters count
// (text after a zero byte is ignored). At the line end the decoded command,
// if any, shows in the next cycle as a single result request: MODO:1..3 sets
// the control mode in any mode, while Sn:value (n = 1..4, value mod 256) and
// C:left,right (speeds mod 65536) are honored only in mode 3. Unmatched or
// empty lines give nothing. Fields not used by the command kind read as zero,
// and o_control_mode always shows the mode after the command. One character
// is taken every cycle unless stalled: each character updates the prefix
// trackers and the two number accumulators directly, so there is no per-line
// decode delay. Input requests stall only while a finished result is held and
// the downstream side stalls it.
module serial_command_line_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_rx_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_command_kind,
    output logic [1:0]          o_servo_number,
    output logic [7:0]          o_servo_value,
    output logic signed [15:0]  o_speed_left,
    output logic signed [15:0]  o_speed_right,
    output logic [1:0]          o_control_mode
);

    scld_pkg::t_line_stat line_stat;
    scld_pkg::t_num_ctl   num1_ctl, num2_ctl;
    logic signed [15:0]   num1_value, num2_value;

    logic       take;
    logic       eol;
    logic       hit;
    logic [1:0] r_mode, n_mode;
    logic       r_valid, n_valid;

    // result payload registers: loaded only with a new result, no reset
    scld_pkg::t_cmd_kind r_kind, n_kind;
    logic [1:0]          r_servo_num, n_servo_num;
    logic [7:0]          r_servo_val, n_servo_val;
    logic signed [15:0]  r_left, n_left;
    logic signed [15:0]  r_right, n_right;
    logic [1:0]          r_res_mode, n_res_mode;

    // Hold input only when a result is parked and downstream is stalled.
    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign eol     = take && (i_rx_byte == scld_pkg::CH_LF || i_rx_byte == scld_pkg::CH_CR);

    scld_line u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_rx_byte),
        .o_stat     (line_stat),
        .o_num1_ctl (num1_ctl),
        .o_num2_ctl (num2_ctl)
    );

    scld_num u_num1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (num1_ctl),
        .i_byte  (i_rx_byte),
        .o_value (num1_value)
    );

    scld_num u_num2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (num2_ctl),
        .i_byte  (i_rx_byte),
        .o_value (num2_value)
    );

    // Decode the finished line from the tracker flags at the line end.
    always_comb begin
        hit         = 1'b0;
        n_mode      = r_mode;
        n_kind      = r_kind;
        n_servo_num = r_servo_num;
        n_servo_val = r_servo_val;
        n_left      = r_left;
        n_right     = r_right;
        n_res_mode  = r_res_mode;
        if (eol) begin
            if (line_stat.mode_hit) begin
                hit         = 1'b1;
                n_mode      = line_stat.mode_val;
                n_kind      = scld_pkg::KIND_MODE;
                n_servo_num = '0;
                n_servo_val = '0;
                n_left      = '0;
                n_right     = '0;
                n_res_mode  = line_stat.mode_val;
            end else if (r_mode == scld_pkg::MODE_REMOTE) begin
                if (line_stat.servo_hit) begin
                    hit         = 1'b1;
                    n_kind      = scld_pkg::KIND_SERVO;
                    n_servo_num = line_stat.servo_num;
                    n_servo_val = num1_value[7:0];
                    n_left      = '0;
                    n_right     = '0;
                    n_res_mode  = r_mode;
                end else if (line_stat.drive_hit) begin
                    hit         = 1'b1;
                    n_kind      = scld_pkg::KIND_DRIVE;
                    n_servo_num = '0;
                    n_servo_val = '0;
                    n_left      = num1_value;
                    n_right     = num2_value;
                    n_res_mode  = r_mode;
                end
            end
        end
        // advance: a new result replaces one being taken; a stalled one holds, else valid drops
        n_valid = hit ? 1'b1 : (r_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_servo_num <= n_servo_num;
        r_servo_val <= n_servo_val;
        r_left      <= n_left;
        r_right     <= n_right;
        r_res_mode  <= n_res_mode;
    end

    assign o_valid        = r_valid;
    assign o_command_kind = r_kind;
    assign o_servo_number = r_servo_num;
    assign o_servo_value  = r_servo_val;
    assign o_speed_left   = r_left;
    assign o_speed_right  = r_right;
    assign o_control_mode = r_res_mode;

endmodule

[hdl/scld_checker.sv]
module scld_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_command_kind,
    input logic [1:0]          o_servo_number,
    input logic [7:0]          o_servo_value,
    input logic signed [15:0]  o_speed_left,
    input logic signed [15:0]  o_speed_right,
    input logic [1:0]          o_control_mode
);

    // A stalled result request holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_command_kind) &&
            $stable(o_servo_value) && $stable(o_speed_left) && $stable(o_speed_right))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_command_kind <= scld_pkg::KIND_DRIVE)
        else $error("undefined command kind");

    a_servo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command_kind != scld_pkg::KIND_SERVO |->
            o_servo_number == 2'd0 && o_servo_value == 8'd0)
        else $error("servo fields set on non-servo result");

    a_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command_kind != scld_pkg::KIND_DRIVE |->
            o_speed_left == 16'sd0 && o_speed_right == 16'sd0)
        else $error("speed fields set on non-drive result");

    a_remote_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_command_kind == scld_pkg::KIND_SERVO ||
                    o_command_kind == scld_pkg::KIND_DRIVE) |->
            o_control_mode == scld_pkg::MODE_REMOTE)
        else $error("servo or drive result outside remote mode");

endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_command_kind (o_command_kind),
    .o_servo_number (o_servo_number),
    .o_servo_value  (o_servo_value),
    .o_speed_left   (o_speed_left),
    .o_speed_right  (o_speed_right),
    .o_control_mode (o_control_mode)
);

[tb/serial_command_line_decoder_tb.sv]
module serial_command_line_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 620;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_PRINTED    = 60;

    // Blanks the number parser skips that the package does not name.
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG
    } t_stall_style;

    // One decoded command as it appears on the result side.
    typedef struct {
        scld_pkg::t_cmd_kind kind;
        logic [1:0]          servo_number;
        logic [7:0]          servo_value;
        logic signed [15:0]  speed_left;
        logic signed [15:0]  speed_right;
        logic [1:0]          control_mode;
    } t_command;

    // Scoreboard: mirror the line buffer and mode, decode at each line end,
    // and hold the commands still owed by the block.
    class command_scoreboard;
        logic [1:0] mode;
        int         held;
        logic [7:0] line [scld_pkg::LINE_LIMIT];
        t_command   pending_commands[$];
        int         errors;

        function new();
            mode   = '0;
            held   = 0;
            errors = 0;
            foreach (line[i]) line[i] = scld_pkg::CH_NUL;
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
            errors++;
        endtask

        function bit blank_char(logic [7:0] c);
            return (c == scld_pkg::CH_SPACE) ||
                   (c >= scld_pkg::CH_TAB && c <= scld_pkg::CH_CR);
        endfunction

        // atoi over line[first..last-1], wrapped to 16 bits.
        function logic [15:0] read_number(int first, int last);
            int          i;
            bit          negative;
            logic [15:0] acc;
            i        = first;
            negative = 1'b0;
            acc      = '0;
            while (i < last && blank_char(line[i])) i++;
            if (i < last && (line[i] == scld_pkg::CH_PLUS ||
                             line[i] == scld_pkg::CH_MINUS)) begin
                negative = (line[i] == scld_pkg::CH_MINUS);
                i++;
            end
            while (i < last && line[i] >= scld_pkg::CH_0 && line[i] <= scld_pkg::CH_9) begin
                acc = acc * 16'd10 + 16'(line[i] - scld_pkg::CH_0);
                i++;
            end
            if (negative) begin
                acc = 16'd0 - acc;
            end
            return acc;
        endfunction

        function bit decode_line(output t_command cmd);
            int          len;
            int          k;
            logic [15:0] value16;
            len = 0;
            // The line stops at the first zero byte held.
            while (len < held && len < scld_pkg::LINE_LIMIT &&
                   line[len] != scld_pkg::CH_NUL) len++;
            cmd.kind         = scld_pkg::KIND_MODE;
            cmd.servo_number = '0;
            cmd.servo_value  = '0;
            cmd.speed_left   = '0;
            cmd.speed_right  = '0;
            cmd.control_mode = mode;
            if (len >= 5 && line[0] == scld_pkg::CH_M && line[1] == scld_pkg::CH_O &&
                line[2] == scld_pkg::CH_D && line[3] == scld_pkg::CH_O &&
                line[4] == scld_pkg::CH_COLON &&
                line[5] >= scld_pkg::CH_1 && line[5] <= scld_pkg::CH_3) begin
                mode             = line[5][1:0];
                cmd.control_mode = mode;
                return 1'b1;
            end
            if (mode != scld_pkg::MODE_REMOTE) begin
                return 1'b0;
            end
            if (len >= 3 && line[0] == scld_pkg::CH_S && line[1] >= scld_pkg::CH_1 &&
                line[1] <= scld_pkg::CH_4 && line[2] == scld_pkg::CH_COLON) begin
                value16          = read_number(3, len);
                cmd.kind         = scld_pkg::KIND_SERVO;
                cmd.servo_number = 2'(line[1] - scld_pkg::CH_1);
                cmd.servo_value  = value16[7:0];
                return 1'b1;
            end
            if (len >= 2 && line[0] == scld_pkg::CH_C && line[1] == scld_pkg::CH_COLON) begin
                k = 2;
                while (k < len && line[k] != scld_pkg::CH_COMMA) k++;
                if (k >= len) begin
                    return 1'b0;
                end
                cmd.kind        = scld_pkg::KIND_DRIVE;
                cmd.speed_left  = read_number(2, k);
                cmd.speed_right = read_number(k + 1, len);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(logic [7:0] b);
            t_command cmd;
            if (b == scld_pkg::CH_LF || b == scld_pkg::CH_CR) begin
                if (decode_line(cmd)) begin
                    pending_commands.push_back(cmd);
                end
                held = 0;
                foreach (line[i]) line[i] = scld_pkg::CH_NUL;
            end else if (held < scld_pkg::LINE_LIMIT) begin
                line[held] = b;
                held++;
            end
        endfunction

        task check_result(t_command got);
            t_command want;
            if (pending_commands.size() == 0) begin
                report($sformatf("result kind %0d with no command pending", got.kind));
            end else begin
                want = pending_commands.pop_front();
                if (got.kind !== want.kind)
                    report($sformatf("command_kind %0d, expected %0d", got.kind, want.kind));
                if (got.servo_number !== want.servo_number)
                    report($sformatf("servo_number %0d, expected %0d",
                                     got.servo_number, want.servo_number));
                if (got.servo_value !== want.servo_value)
                    report($sformatf("servo_value %0d, expected %0d",
                                     got.servo_value, want.servo_value));
                if (got.speed_left !== want.speed_left)
                    report($sformatf("speed_left %0d, expected %0d",
                                     got.speed_left, want.speed_left));
                if (got.speed_right !== want.speed_right)
                    report($sformatf("speed_right %0d, expected %0d",
                                     got.speed_right, want.speed_right));
                if (got.control_mode !== want.control_mode)
                    report($sformatf("control_mode %0d, expected %0d",
                                     got.control_mode, want.control_mode));
            end
        endtask
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic [7:0]         i_rx_byte  = 8'h00;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_command_kind;
    logic [1:0]         o_servo_number;
    logic [7:0]         o_servo_value;
    logic signed [15:0] o_speed_left;
    logic signed [15:0] o_speed_right;
    logic [1:0]         o_control_mode;

    command_scoreboard board;
    logic [7:0]        line_text[$];
    int                sent;
    int                burst_left;

    t_stall_style      stall_style = STALL_NONE;
    int                style_left  = 0;
    int                hold_left   = 0;

    serial_command_line_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_kind (o_command_kind),
        .o_servo_number (o_servo_number),
        .o_servo_value  (o_servo_value),
        .o_speed_left   (o_speed_left),
        .o_speed_right  (o_speed_right),
        .o_control_mode (o_control_mode)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    endfunction

    // Append a number as a user might type it: optional blanks and sign,
    // zero to seven digits (enough to wrap 16 bits), sometimes trailing junk.
    function void add_number();
        int r;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0:       line_text.push_back(scld_pkg::CH_SPACE);
                    1:       line_text.push_back(scld_pkg::CH_TAB);
                    2:       line_text.push_back(CH_VT);
                    default: line_text.push_back(CH_FF);
                endcase
            end
        end
        r = $urandom_range(0, 9);
        if (r < 2) begin
            line_text.push_back(scld_pkg::CH_PLUS);
        end else if (r < 5) begin
            line_text.push_back(scld_pkg::CH_MINUS);
        end
        r = $urandom_range(0, 9);
        repeat (r == 0 ? 0 : (r < 8 ? $urandom_range(1, 3) : $urandom_range(4, 7))) begin
            line_text.push_back(8'(scld_pkg::CH_0 + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) begin
            line_text.push_back(scld_pkg::CH_D);
        end
    endfunction

    // Build one random line with its terminator. Most lines are well formed
    // commands with random numbers; the rest are noise, long lines, empty
    // lines and lines with a zero byte or a corrupted character.
    function void build_line();
        int pick;
        int r;
        int pad_to;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            add_text("MODO:");
            r = $urandom_range(0, 19);
            if (r < 12) begin
                line_text.push_back(scld_pkg::CH_3);
            end else if (r < 17) begin
                line_text.push_back(8'(scld_pkg::CH_1 + (r & 1)));
            end else begin
                line_text.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) == 0) add_number();
        end else if (pick < 42) begin
            line_text.push_back(scld_pkg::CH_S);
            if ($urandom_range(0, 9) != 0) begin
                line_text.push_back(8'(scld_pkg::CH_1 + $urandom_range(0, 3)));
            end else begin
                line_text.push_back(8'($urandom_range(0, 255)));
            end
            line_text.push_back($urandom_range(0, 19) == 0 ? scld_pkg::CH_SPACE
                                                          : scld_pkg::CH_COLON);
            add_number();
        end else if (pick < 72) begin
            add_text("C:");
            add_number();
            if ($urandom_range(0, 6) != 0) begin
                line_text.push_back(scld_pkg::CH_COMMA);
                add_number();
            end
            if ($urandom_range(0, 6) == 0) begin
                line_text.push_back(scld_pkg::CH_COMMA);
                add_number();
            end
        end else if (pick < 82) begin
            repeat ($urandom_range(1, 18)) line_text.push_back(8'($urandom));
        end else if (pick < 90) begin
            // Straddle the line limit so the truncation edge gets hit.
            if (pick < 85) begin
                add_text("C:1,");
            end else begin
                add_text("S2:");
            end
            pad_to = $urandom_range(13, 24);
            while (line_text.size() < pad_to) begin
                line_text.push_back(8'(scld_pkg::CH_0 + $urandom_range(0, 9)));
            end
        end
        // Otherwise leave the line empty.
        if (line_text.size() != 0 && $urandom_range(0, 19) == 0) begin
            line_text[$urandom_range(0, line_text.size() - 1)] = scld_pkg::CH_NUL;
        end
        if (line_text.size() != 0 && $urandom_range(0, 19) == 0) begin
            line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom);
        end
        r = $urandom_range(0, 9);
        line_text.push_back(r < 5 ? scld_pkg::CH_LF : scld_pkg::CH_CR);
        if (r == 9) begin
            line_text.push_back(scld_pkg::CH_LF);
        end
    endfunction

    // Offer one request and hold it until accepted. Requests go out in
    // bursts; drop valid between bursts for a random gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        board.note_request(b);
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid   <= 1'b0;
            i_rx_byte <= 8'($urandom);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_line();
        foreach (line_text[i]) send_byte(line_text[i]);
        line_text.delete();
    endtask

    // Result side: check each accepted result, then pick the next stall value
    // from a style that is re-picked at random intervals.
    always @(posedge i_clk) begin
        t_command got;
        logic     stall_next;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            got.kind         = scld_pkg::t_cmd_kind'(o_command_kind);
            got.servo_number = o_servo_number;
            got.servo_value  = o_servo_value;
            got.speed_left   = o_speed_left;
            got.speed_right  = o_speed_right;
            got.control_mode = o_control_mode;
            board.check_result(got);
        end
        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 2));
            style_left  = $urandom_range(40, 200);
        end else begin
            style_left--;
        end
        case (stall_style)
            STALL_NONE: begin
                stall_next = 1'b0;
            end
            STALL_RANDOM: begin
                stall_next = ($urandom_range(0, 2) == 0);
            end
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    stall_next = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    hold_left  = $urandom_range(4, 20);
                    stall_next = 1'b1;
                end else begin
                    stall_next = 1'b0;
                end
            end
        endcase
        i_stall <= stall_next;
    end

    // Watchdog: end the run once nothing moves on either side for too long.
    initial begin
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("** serial_command_line_decoder: FAILED **");
        $finish;
    end

    initial begin
        board      = new();
        sent       = 0;
        burst_left = $urandom_range(1, 16);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: enter remote mode, servo at full scale, speeds at both
        // ends of the signed range.
        add_text("MODO:3");
        line_text.push_back(scld_pkg::CH_LF);
        add_text("S4:255");
        line_text.push_back(scld_pkg::CH_CR);
        add_text("C:32767,-32768");
        line_text.push_back(scld_pkg::CH_LF);
        send_line();

        while (sent < ITEM_TARGET) begin
            build_line();
            send_line();
        end
        i_valid <= 1'b0;

        // Drain the owed commands, then give a stray result time to show.
        while (board.pending_commands.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("** serial_command_line_decoder: PASSED **");
        end else begin
            $display("** serial_command_line_decoder: FAILED **");
        end
        $finish;
    end

endmodule
